// ===== sv/servo_slew_door_sequencer_top_assert.svh =====
// Assertion macros for the servo slew door sequencer.
`ifndef SERVO_SLEW_DOOR_SEQUENCER_TOP_ASSERT_SVH
`define SERVO_SLEW_DOOR_SEQUENCER_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SSD_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssd_pkg.sv =====
// Package with constants, codes and types of the servo slew door sequencer.
package ssd_pkg;

    localparam logic [7:0]  MAX_ANGLE  = 8'd180;
    localparam logic [13:0] DUTY_FULL  = 14'd16383;
    localparam logic [15:0] PERIOD_US  = 16'd20000;

    // x / 180 = (x >> 2) / 45, exact for 21-bit quotients of the shift
    localparam int          DIV1_SHIFT = 2;
    localparam int          DIV1_K     = 27;
    localparam logic [21:0] DIV1_RECIP = 22'd2982617;

    // x / 20000 = (x >> 5) / 625, exact for 24-bit quotients of the shift
    localparam int          DIV2_SHIFT = 5;
    localparam int          DIV2_K     = 34;
    localparam logic [24:0] DIV2_RECIP = 25'd27487791;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_MOVE  = 2'd1;
    localparam logic [1:0] FUNC_OPEN  = 2'd2;
    localparam logic [1:0] FUNC_CLOSE = 2'd3;

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RAMP     = 2'd1;
    localparam logic [1:0] PH_HOLD     = 2'd2;
    localparam logic [1:0] PH_OPENWAIT = 2'd3;

    localparam logic [2:0] REG_MIN_PULSE   = 3'd0;
    localparam logic [2:0] REG_MAX_PULSE   = 3'd1;
    localparam logic [2:0] REG_STEP_ANGLE  = 3'd2;
    localparam logic [2:0] REG_STEP_PERIOD = 3'd3;
    localparam logic [2:0] REG_HOLD        = 3'd4;
    localparam logic [2:0] REG_OPEN_ANGLE  = 3'd5;
    localparam logic [2:0] REG_CLOSE_ANGLE = 3'd6;
    localparam logic [2:0] REG_OPEN_DUR    = 3'd7;

    localparam logic [14:0] MIN_PULSE_RST   = 15'd500;
    localparam logic [14:0] MAX_PULSE_RST   = 15'd2500;
    localparam logic [7:0]  STEP_ANGLE_RST  = 8'd2;
    localparam logic [15:0] STEP_PERIOD_RST = 16'd20;
    localparam logic [15:0] HOLD_RST        = 16'd500;
    localparam logic [7:0]  OPEN_ANGLE_RST  = 8'd80;
    localparam logic [7:0]  CLOSE_ANGLE_RST = 8'd135;
    localparam logic [19:0] OPEN_DUR_RST    = 20'd2000;

    typedef struct packed {
        logic       pwm_on;
        logic [7:0] angle_now;
        logic       door_open;
        logic       busy_res;
        logic       status;
    } ssd_flags_t;

    function automatic logic [7:0] clamp_angle(input logic [7:0] a);
        return (a > MAX_ANGLE) ? MAX_ANGLE : a;
    endfunction

endpackage

// ===== sv/servo_slew_door_sequencer_top.sv =====
// Servo slew-rate limiter with door sequencer: state update and duty pipeline.
//
// Input channel (in_valid/in_stall, func, angle) carries one word per 1 ms tick
// or command. Output channel (out_valid/out_stall) returns one result word per
// input word, in order: PWM enable, 14-bit duty, current angle, door state,
// busy flag and refusal status.
// The sequencer state is updated as a word leaves the input register; the duty for
// the new angle then runs through a seven-stage multiply-by-reciprocal chain.
// A taken word passes the input register, stage one and the duty stages to the output.
// Throughput is one word per cycle while the receiver does not stall; every stage
// holds one word, so up to nine words are in flight.
// When the receiver stalls, the result register holds and the stages behind it
// fill up; in_stall rises only once every stage holds a word.
// Configuration registers sit on the APB port at byte address 4*index and are
// to be written by the user only while no word is in flight; the block does not enforce it.
// Reset (rst_n low, asynchronous) empties the pipeline, loads the register
// defaults and puts the servo at angle 135 with PWM off and no move running.
`include "servo_slew_door_sequencer_top_assert.svh"

module servo_slew_door_sequencer_top
    import ssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  angle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pwm_on,
    output logic [13:0] duty,
    output logic [7:0]  angle_now,
    output logic        door_open,
    output logic        busy_res,
    output logic        status
);

    localparam int LAST = 8;

    // configuration
    logic [14:0] min_pulse_reg;
    logic [14:0] max_pulse_reg;
    logic [7:0]  step_angle_reg;
    logic [15:0] step_period_reg;
    logic [15:0] hold_reg;
    logic [7:0]  open_angle_reg;
    logic [7:0]  close_angle_reg;
    logic [19:0] open_dur_reg;
    logic [14:0] span_reg;
    logic        cfg_wr;

    // sequencer state
    logic [7:0]  angle_reg,      angle_next;
    logic [7:0]  target_reg,     target_next;
    logic [1:0]  phase_reg,      phase_next;
    logic [19:0] tick_reg,       tick_next;
    logic        close_pend_reg, close_pend_next;
    logic        door_reg,       door_next;
    logic        pwm_reg,        pwm_next;
    logic        status_next;
    logic        upd;

    // step logic
    logic        move_go;
    logic        ramp_go;
    logic [7:0]  move_tgt;
    logic [7:0]  step_tgt;
    logic [7:0]  step_size;
    logic [8:0]  step_sum;
    logic [7:0]  step_nx;
    logic [16:0] hold_len;

    // pipeline
    logic [LAST:0]   vld_reg;
    logic [LAST+1:0] rdy;
    logic [1:0]      s0_func_reg;
    logic [7:0]      s0_angle_reg;
    ssd_flags_t      flg_reg [1:LAST];
    logic [22:0]     prod_reg;
    logic [31:0]     pp1h_reg;
    logic [32:0]     pp1l_reg;
    logic [42:0]     quo_sum;
    logic [14:0]     quo_reg;
    logic [15:0]     pulse_reg;
    logic            sat_pulse;
    logic [14:0]     pulse_cap;
    logic [28:0]     scaled;
    logic [23:0]     n2_reg;
    logic            sat6_reg;
    logic            sat7_reg;
    logic [36:0]     pp2h_reg;
    logic [36:0]     pp2l_reg;
    logic [48:0]     duty_sum;
    logic [13:0]     duty_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg   <= MIN_PULSE_RST;
            max_pulse_reg   <= MAX_PULSE_RST;
            step_angle_reg  <= STEP_ANGLE_RST;
            step_period_reg <= STEP_PERIOD_RST;
            hold_reg        <= HOLD_RST;
            open_angle_reg  <= OPEN_ANGLE_RST;
            close_angle_reg <= CLOSE_ANGLE_RST;
            open_dur_reg    <= OPEN_DUR_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MIN_PULSE:   min_pulse_reg   <= pwdata[14:0];
                REG_MAX_PULSE:   max_pulse_reg   <= pwdata[14:0];
                REG_STEP_ANGLE:  step_angle_reg  <= pwdata[7:0];
                REG_STEP_PERIOD: step_period_reg <= pwdata[15:0];
                REG_HOLD:        hold_reg        <= pwdata[15:0];
                REG_OPEN_ANGLE:  open_angle_reg  <= pwdata[7:0];
                REG_CLOSE_ANGLE: close_angle_reg <= pwdata[7:0];
                REG_OPEN_DUR:    open_dur_reg    <= pwdata[19:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MIN_PULSE:   prdata = {17'd0, min_pulse_reg};
            REG_MAX_PULSE:   prdata = {17'd0, max_pulse_reg};
            REG_STEP_ANGLE:  prdata = {24'd0, step_angle_reg};
            REG_STEP_PERIOD: prdata = {16'd0, step_period_reg};
            REG_HOLD:        prdata = {16'd0, hold_reg};
            REG_OPEN_ANGLE:  prdata = {24'd0, open_angle_reg};
            REG_CLOSE_ANGLE: prdata = {24'd0, close_angle_reg};
            REG_OPEN_DUR:    prdata = {12'd0, open_dur_reg};
            default:         prdata = '0;
        endcase
    end

    // span is refreshed every cycle; a new limit reaches prod_reg through span_reg
    always_ff @(posedge clk)
    begin
        span_reg <= (max_pulse_reg > min_pulse_reg) ? (max_pulse_reg - min_pulse_reg) : '0;
    end

    // ---------------- pipeline flow ----------------
    always_comb
    begin
        rdy[LAST+1] = !out_stall;
        for (int i = LAST; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_stall = !rdy[0];
    assign upd      = vld_reg[0] && rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i <= LAST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s0_func_reg  <= func;
            s0_angle_reg <= angle;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        angle_next      = angle_reg;
        target_next     = target_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        close_pend_next = close_pend_reg;
        door_next       = door_reg;
        pwm_next        = pwm_reg;
        status_next     = 1'b0;
        move_go         = 1'b0;
        ramp_go         = 1'b0;
        move_tgt        = '0;

        if (s0_func_reg == FUNC_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                if (tick_reg > 20'd1)
                begin
                    tick_next = tick_reg - 20'd1;
                end
                else
                begin
                    case (phase_reg)
                        PH_RAMP:
                        begin
                            ramp_go = 1'b1;
                        end
                        PH_HOLD:
                        begin
                            pwm_next = 1'b0;
                            if (close_pend_reg)
                            begin
                                close_pend_next = 1'b0;
                                door_next       = 1'b1;
                                phase_next      = PH_OPENWAIT;
                                tick_next       = open_dur_reg;
                            end
                            else
                            begin
                                door_next  = 1'b0;
                                phase_next = PH_IDLE;
                                tick_next  = '0;
                            end
                        end
                        PH_OPENWAIT:
                        begin
                            move_go  = 1'b1;
                            move_tgt = clamp_angle(close_angle_reg);
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                        end
                    endcase
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            status_next = 1'b1;
        end
        else
        begin
            case (s0_func_reg)
                FUNC_MOVE:
                begin
                    close_pend_next = 1'b0;
                    move_go         = 1'b1;
                    move_tgt        = clamp_angle(s0_angle_reg);
                end
                FUNC_OPEN:
                begin
                    close_pend_next = 1'b1;
                    move_go         = 1'b1;
                    move_tgt        = clamp_angle(open_angle_reg);
                end
                FUNC_CLOSE:
                begin
                    close_pend_next = 1'b0;
                    move_go         = 1'b1;
                    move_tgt        = clamp_angle(close_angle_reg);
                end
                default: ;
            endcase
        end

        // one ramp step toward the target, never past it
        step_tgt  = move_go ? move_tgt : target_reg;
        step_size = (step_angle_reg == '0) ? 8'd1 : step_angle_reg;
        step_sum  = {1'b0, angle_reg} + {1'b0, step_size};
        if (angle_reg < step_tgt)
        begin
            step_nx = (step_sum > {1'b0, step_tgt}) ? step_tgt : step_sum[7:0];
        end
        else
        begin
            step_nx = (angle_reg <= step_size) ? '0 : (angle_reg - step_size);
            if (step_nx < step_tgt)
            begin
                step_nx = step_tgt;
            end
        end
        hold_len = {1'b0, step_period_reg} + {1'b0, hold_reg};

        if (move_go)
        begin
            pwm_next    = 1'b1;
            target_next = move_tgt;
        end

        if (move_go && (angle_reg == move_tgt))
        begin
            phase_next = PH_HOLD;
            tick_next  = {4'd0, hold_reg};
        end
        else if (move_go || ramp_go)
        begin
            angle_next = step_nx;
            if (step_nx == step_tgt)
            begin
                phase_next = PH_HOLD;
                tick_next  = {3'd0, hold_len};
            end
            else
            begin
                phase_next = PH_RAMP;
                tick_next  = {4'd0, step_period_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg      <= CLOSE_ANGLE_RST;
            target_reg     <= '0;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            close_pend_reg <= 1'b0;
            door_reg       <= 1'b0;
            pwm_reg        <= 1'b0;
        end
        else if (upd)
        begin
            angle_reg      <= angle_next;
            target_reg     <= target_next;
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            close_pend_reg <= close_pend_next;
            door_reg       <= door_next;
            pwm_reg        <= pwm_next;
        end
    end

    // ---------------- duty pipeline ----------------
    // pulse = min + angle*span/180, duty = pulse*16383/20000, saturated
    assign quo_sum   = {pp1h_reg, 11'd0} + {10'd0, pp1l_reg};
    assign sat_pulse = pulse_reg > PERIOD_US;
    assign pulse_cap = sat_pulse ? '0 : pulse_reg[14:0];
    assign scaled    = {pulse_cap, 14'd0} - {14'd0, pulse_cap};
    assign duty_sum  = {pp2h_reg, 12'd0} + {12'd0, pp2l_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            flg_reg[1] <= '{pwm_on:    pwm_next,
                            angle_now: angle_next,
                            door_open: door_next,
                            busy_res:  (phase_next != PH_IDLE),
                            status:    status_next};
        end
        for (int i = 2; i <= LAST; i++)
        begin
            if (rdy[i])
            begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
        if (rdy[2])
        begin
            prod_reg <= 23'(flg_reg[1].angle_now) * 23'(span_reg);
        end
        if (rdy[3])
        begin
            pp1h_reg <= 32'(prod_reg[22:11+DIV1_SHIFT]) * 32'(DIV1_RECIP);
            pp1l_reg <= 33'(prod_reg[10+DIV1_SHIFT:DIV1_SHIFT]) * 33'(DIV1_RECIP);
        end
        if (rdy[4])
        begin
            quo_reg <= quo_sum[DIV1_K+14:DIV1_K];
        end
        if (rdy[5])
        begin
            pulse_reg <= {1'b0, min_pulse_reg} + {1'b0, quo_reg};
        end
        if (rdy[6])
        begin
            n2_reg   <= scaled[28:DIV2_SHIFT];
            sat6_reg <= sat_pulse;
        end
        if (rdy[7])
        begin
            pp2h_reg <= 37'(n2_reg[23:12]) * 37'(DIV2_RECIP);
            pp2l_reg <= 37'(n2_reg[11:0]) * 37'(DIV2_RECIP);
            sat7_reg <= sat6_reg;
        end
        if (rdy[8])
        begin
            duty_reg <= sat7_reg ? DUTY_FULL : duty_sum[DIV2_K+13:DIV2_K];
        end
    end

    assign out_valid = vld_reg[LAST];
    assign pwm_on    = flg_reg[LAST].pwm_on;
    assign duty      = duty_reg;
    assign angle_now = flg_reg[LAST].angle_now;
    assign door_open = flg_reg[LAST].door_open;
    assign busy_res  = flg_reg[LAST].busy_res;
    assign status    = flg_reg[LAST].status;

    // ---------------- assertions ----------------
    `SSD_ASSERT_IMPLIES(a_idle_quiet, phase_reg == PH_IDLE,
        !pwm_reg && !door_reg && (tick_reg == '0), "idle with pwm, door flag or wait count set")
    `SSD_ASSERT_HOLDS(a_angle_range, angle_reg <= MAX_ANGLE, "current angle beyond maximum")
    `SSD_ASSERT_IMPLIES(a_stall_full, in_stall, (&vld_reg) && out_stall,
        "input stalled with a free stage")
    `SSD_ASSERT_NEXT(a_upd_lands, upd, vld_reg[1], "updated word lost before stage one")

endmodule

// ===== sim/servo_slew_door_sequencer_top_tb.sv =====
// Self-checking testbench for the servo slew door sequencer: directed and random words.
`timescale 1ns / 1ps

module servo_slew_door_sequencer_top_tb;
    import ssd_pkg::*;

    typedef struct packed {
        logic        pwm_on;
        logic [13:0] duty;
        logic [7:0]  angle_now;
        logic        door_open;
        logic        busy_res;
        logic        status;
    } servo_word_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  func      = FUNC_TICK;
    logic [7:0]  angle     = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        pwm_on;
    logic [13:0] duty;
    logic [7:0]  angle_now;
    logic        door_open;
    logic        busy_res;
    logic        status;

    // register copies
    logic [14:0] cfg_min_pulse, cfg_max_pulse;
    logic [7:0]  cfg_step, cfg_open_angle, cfg_close_angle;
    logic [15:0] cfg_period, cfg_hold;
    logic [19:0] cfg_open_dur;

    // sequencer state as predicted
    logic [7:0]  srv_angle, srv_target;
    logic [1:0]  srv_phase;
    logic [20:0] srv_ticks;
    logic        srv_close_pending, srv_door_open, srv_pwm;

    servo_word_t pending_words[$];
    int          mismatch_count = 0;
    int          sink_wait      = 0;
    bit          no_idle        = 1'b0;

    servo_slew_door_sequencer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .angle     (angle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pwm_on    (pwm_on),
        .duty      (duty),
        .angle_now (angle_now),
        .door_open (door_open),
        .busy_res  (busy_res),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one ramp step toward the target, never past it and never below zero
    function automatic void step_toward();
        logic [7:0] st;
        logic [8:0] nx;
        st = (cfg_step == 8'd0) ? 8'd1 : cfg_step;
        if (srv_angle < srv_target)
        begin
            nx = srv_angle + st;
            if (nx > srv_target)
                nx = srv_target;
        end
        else
        begin
            nx = (srv_angle <= st) ? 9'd0 : srv_angle - st;
            if (nx < srv_target)
                nx = srv_target;
        end
        srv_angle = nx[7:0];
        if (srv_angle == srv_target)
        begin
            srv_phase = PH_HOLD;
            srv_ticks = cfg_period + cfg_hold;
        end
        else
        begin
            srv_phase = PH_RAMP;
            srv_ticks = cfg_period;
        end
    endfunction

    function automatic void begin_move(input logic [7:0] goal);
        srv_pwm    = 1'b1;
        srv_target = (goal > MAX_ANGLE) ? MAX_ANGLE : goal;
        if (srv_angle == srv_target)
        begin
            srv_phase = PH_HOLD;
            srv_ticks = cfg_hold;
        end
        else
            step_toward();
    endfunction

    // advances the predicted sequencer by one word and returns its result
    function automatic servo_word_t servo_next_word(input logic [1:0] f, input logic [7:0] a);
        servo_word_t     w;
        logic            refused;
        longint unsigned span, pulse, d;
        refused = 1'b0;
        if (f == FUNC_TICK)
        begin
            if (srv_phase != PH_IDLE)
            begin
                if (srv_ticks > 21'd1)
                    srv_ticks = srv_ticks - 21'd1;
                else
                begin
                    case (srv_phase)
                        PH_RAMP: step_toward();
                        PH_HOLD:
                        begin
                            srv_pwm = 1'b0;
                            if (srv_close_pending)
                            begin
                                srv_close_pending = 1'b0;
                                srv_door_open     = 1'b1;
                                srv_phase         = PH_OPENWAIT;
                                srv_ticks         = cfg_open_dur;
                            end
                            else
                            begin
                                srv_door_open = 1'b0;
                                srv_phase     = PH_IDLE;
                                srv_ticks     = '0;
                            end
                        end
                        default: begin_move(cfg_close_angle);
                    endcase
                end
            end
        end
        else if (srv_phase != PH_IDLE)
            refused = 1'b1;
        else
        begin
            srv_close_pending = (f == FUNC_OPEN);
            case (f)
                FUNC_MOVE: begin_move(a);
                FUNC_OPEN: begin_move(cfg_open_angle);
                default:   begin_move(cfg_close_angle);
            endcase
        end

        span = 0;
        if (cfg_max_pulse > cfg_min_pulse)
            span = cfg_max_pulse - cfg_min_pulse;
        pulse = cfg_min_pulse + (srv_angle * span) / MAX_ANGLE;
        d = (pulse * DUTY_FULL) / PERIOD_US;
        if (d > DUTY_FULL)
            d = DUTY_FULL;

        w.pwm_on    = srv_pwm;
        w.duty      = d[13:0];
        w.angle_now = srv_angle;
        w.door_open = srv_door_open;
        w.busy_res  = (srv_phase != PH_IDLE);
        w.status    = refused;
        return w;
    endfunction

    task automatic report_error(input string msg);
        if (mismatch_count < 50)
            $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // result side: compare each word taken, then stall for a random count unless no_idle
    always @(posedge clk)
    begin : sink
        servo_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
                report_error("result word with nothing expected");
            else
            begin
                want = pending_words.pop_front();
                check_field("pwm_on", pwm_on, want.pwm_on);
                check_field("duty", duty, want.duty);
                check_field("angle_now", angle_now, want.angle_now);
                check_field("door_open", door_open, want.door_open);
                check_field("busy_res", busy_res, want.busy_res);
                check_field("status", status, want.status);
            end
            sink_wait = no_idle ? 0 : $urandom_range(0, 4);
        end
        else if (sink_wait > 0)
            sink_wait--;
        out_stall <= (sink_wait != 0);
    end

    task automatic send_word(input logic [1:0] f, input logic [7:0] a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        angle    <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(servo_next_word(f, a));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_PULSE:   cfg_min_pulse   = value[14:0];
            REG_MAX_PULSE:   cfg_max_pulse   = value[14:0];
            REG_STEP_ANGLE:  cfg_step        = value[7:0];
            REG_STEP_PERIOD: cfg_period      = value[15:0];
            REG_HOLD:        cfg_hold        = value[15:0];
            REG_OPEN_ANGLE:  cfg_open_angle  = value[7:0];
            REG_CLOSE_ANGLE: cfg_close_angle = value[7:0];
            default:         cfg_open_dur    = value[19:0];
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input int min_p, input int max_p, input int step, input int period,
                             input int hold, input int open_a, input int close_a, input int dur);
        write_reg(REG_MIN_PULSE, min_p);
        write_reg(REG_MAX_PULSE, max_p);
        write_reg(REG_STEP_ANGLE, step);
        write_reg(REG_STEP_PERIOD, period);
        write_reg(REG_HOLD, hold);
        write_reg(REG_OPEN_ANGLE, open_a);
        write_reg(REG_CLOSE_ANGLE, close_a);
        write_reg(REG_OPEN_DUR, dur);
    endtask

    task automatic test_reset_state();
        send_word(FUNC_TICK, 8'd0);
    endtask

    // move, busy refusals, full open cycle and close, all with one-tick waits
    task automatic test_command_flow();
        wait_for_results();
        write_all(500, 2500, 90, 1, 0, 255, 0, 0);
        send_word(FUNC_TICK, 8'd255);
        send_word(FUNC_MOVE, 8'd255);
        send_word(FUNC_OPEN, 8'd0);
        send_word(FUNC_CLOSE, 8'd0);
        send_word(FUNC_MOVE, 8'd0);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_OPEN, 8'd17);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_CLOSE, 8'd0);
        send_word(FUNC_TICK, 8'd0);
    endtask

    // duty at full angle for empty, inverted and saturating pulse ranges
    task automatic test_pulse_range();
        int lo_us[5] = '{0, 32767, 20000, 0, 1000};
        int hi_us[5] = '{0, 0, 20000, 32767, 500};
        wait_for_results();
        write_reg(REG_STEP_ANGLE, 255);
        send_word(FUNC_MOVE, 8'd180);
        send_word(FUNC_TICK, 8'd0);
        for (int k = 0; k < 5; k++)
        begin
            wait_for_results();
            write_reg(REG_MIN_PULSE, lo_us[k]);
            write_reg(REG_MAX_PULSE, hi_us[k]);
            send_word(FUNC_TICK, 8'd0);
        end
    endtask

    // a step size of zero moves one degree per step
    task automatic test_zero_step();
        wait_for_results();
        write_all(500, 2500, 0, 1, 0, 80, 135, 0);
        send_word(FUNC_MOVE, 8'd178);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_TICK, 8'd0);
    endtask

    task automatic test_random_traffic();
        for (int batch = 0; batch < 6; batch++)
        begin
            wait_for_results();
            no_idle = (batch == 2);
            write_all(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                  : $urandom_range(300, 1500),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                  : $urandom_range(1500, 3000),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 45),
                      $urandom_range(1, 3), $urandom_range(0, 3),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 4));
            for (int n = 0; n < 100; n++)
            begin
                // on odd batches, hold off the sender halfway until the pipeline drains
                if (n == 50 && batch[0])
                    wait_for_results();
                if ($urandom_range(0, 9) < 6)
                    send_word(FUNC_TICK, 8'($urandom_range(0, 255)));
                else
                    send_word(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    // widest waits and pulses; the sequencer stays busy to the end
    task automatic test_extreme_config();
        while (srv_phase != PH_IDLE)
            send_word(FUNC_TICK, 8'd0);
        wait_for_results();
        write_all(20000, 20000, 180, 65535, 65535, 180, 0, 1048575);
        send_word(FUNC_OPEN, 8'd0);
        send_word(FUNC_TICK, 8'd0);
        send_word(FUNC_MOVE, 8'd90);
        send_word(FUNC_CLOSE, 8'd0);
        send_word(FUNC_TICK, 8'd0);
    endtask

    initial
    begin
        cfg_min_pulse     = MIN_PULSE_RST;
        cfg_max_pulse     = MAX_PULSE_RST;
        cfg_step          = STEP_ANGLE_RST;
        cfg_period        = STEP_PERIOD_RST;
        cfg_hold          = HOLD_RST;
        cfg_open_angle    = OPEN_ANGLE_RST;
        cfg_close_angle   = CLOSE_ANGLE_RST;
        cfg_open_dur      = OPEN_DUR_RST;
        srv_angle         = CLOSE_ANGLE_RST;
        srv_target        = '0;
        srv_phase         = PH_IDLE;
        srv_ticks         = '0;
        srv_close_pending = 1'b0;
        srv_door_open     = 1'b0;
        srv_pwm           = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_command_flow();
        test_pulse_range();
        test_zero_step();
        test_random_traffic();
        test_extreme_config();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
